// File: hw/rtl/csdc_pkg.sv
// ----------------------------------------------------------------------------
// csdc_pkg: clock setting display controller package
// Shared types, codes and helper functions for the controller.
// ----------------------------------------------------------------------------
package csdc_pkg;

  // event codes carried by the mode field
  localparam logic [1:0] EvtPoll = 2'd0;
  localparam logic [1:0] EvtTime = 2'd1;
  localparam logic [1:0] EvtTick = 2'd2;

  // field selection codes; any other value means no field
  localparam logic [1:0] FieldHours   = 2'd0;
  localparam logic [1:0] FieldMinutes = 2'd1;
  localparam logic [1:0] FieldNone    = 2'd2;

  localparam logic [15:0] TimeoutReset = 16'd200;
  localparam logic [3:0]  HoursMax     = 4'd12;
  localparam logic [5:0]  MinutesMax   = 6'd59;
  localparam logic [6:0]  Hours12Bit   = 7'h40;

  typedef enum logic [1:0] {
    ModeIdle     = 2'd0,
    ModeSettings = 2'd1,
    ModeTimeout  = 2'd2
  } clock_mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic       button1_level;
    logic       button2_level;
    logic [7:0] rtc_seconds_byte;
    logic [7:0] rtc_minutes_byte;
    logic [7:0] rtc_hours_byte;
  } csdc_in_t;

  typedef struct packed {
    logic       display_valid;
    logic [6:0] seg_minute_ones;
    logic [6:0] seg_minute_tens;
    logic [6:0] seg_hour_ones;
    logic [6:0] seg_hour_tens;
    logic       led_level;
    logic       rtc_write_valid;
    logic [7:0] rtc_seconds_out;
    logic [7:0] rtc_minutes_out;
    logic [6:0] rtc_hours_out;
  } csdc_res_t;

  // seven-segment pattern, bit 0 is segment a; above nine is blank
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'b0111111;
      4'd1:    s = 7'b0000110;
      4'd2:    s = 7'b1011011;
      4'd3:    s = 7'b1001111;
      4'd4:    s = 7'b1100110;
      4'd5:    s = 7'b1101101;
      4'd6:    s = 7'b1111101;
      4'd7:    s = 7'b0000111;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1101111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

  // minutes into {tens, ones}
  function automatic logic [7:0] split_min(input logic [5:0] m);
    logic [3:0] t;
    logic [5:0] r;
    t = 4'd0;
    r = m;
    if (m >= 6'd60) begin
      t = 4'd6;
      r = m - 6'd60;
    end else if (m >= 6'd50) begin
      t = 4'd5;
      r = m - 6'd50;
    end else if (m >= 6'd40) begin
      t = 4'd4;
      r = m - 6'd40;
    end else if (m >= 6'd30) begin
      t = 4'd3;
      r = m - 6'd30;
    end else if (m >= 6'd20) begin
      t = 4'd2;
      r = m - 6'd20;
    end else if (m >= 6'd10) begin
      t = 4'd1;
      r = m - 6'd10;
    end
    return {t, r[3:0]};
  endfunction

  // hours into {tens, ones}
  function automatic logic [7:0] split_hr(input logic [3:0] h);
    logic [7:0] v;
    if (h >= 4'd10) begin
      v = {4'd1, h - 4'd10};
    end else begin
      v = {4'd0, h};
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/csdc_if.sv
// ----------------------------------------------------------------------------
// csdc_if: controller channel interfaces
// Valid/ready channels for event words in and result words out.
// ----------------------------------------------------------------------------
interface csdc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       button1_level;
  logic       button2_level;
  logic [7:0] rtc_seconds_byte;
  logic [7:0] rtc_minutes_byte;
  logic [7:0] rtc_hours_byte;

  modport source (
    output valid, mode, button1_level, button2_level,
           rtc_seconds_byte, rtc_minutes_byte, rtc_hours_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, button1_level, button2_level,
           rtc_seconds_byte, rtc_minutes_byte, rtc_hours_byte,
    output ready
  );
endinterface

interface csdc_res_if;
  logic       valid;
  logic       ready;
  logic       display_valid;
  logic [6:0] seg_minute_ones;
  logic [6:0] seg_minute_tens;
  logic [6:0] seg_hour_ones;
  logic [6:0] seg_hour_tens;
  logic       led_level;
  logic       rtc_write_valid;
  logic [7:0] rtc_seconds_out;
  logic [7:0] rtc_minutes_out;
  logic [6:0] rtc_hours_out;

  modport source (
    output valid, display_valid, seg_minute_ones, seg_minute_tens,
           seg_hour_ones, seg_hour_tens, led_level, rtc_write_valid,
           rtc_seconds_out, rtc_minutes_out, rtc_hours_out,
    input  ready
  );
  modport sink (
    input  valid, display_valid, seg_minute_ones, seg_minute_tens,
           seg_hour_ones, seg_hour_tens, led_level, rtc_write_valid,
           rtc_seconds_out, rtc_minutes_out, rtc_hours_out,
    output ready
  );
endinterface

// File: hw/rtl/clock_setting_display_controller.sv
// ----------------------------------------------------------------------------
// clock_setting_display_controller: clock setting and display controller
// Each accepted event word waits in the input register until the result
// register is free or draining; one word per cycle sustained while res_o.ready
// holds. Input register -> event logic in csdc_core -> result register;
// a word is taken while the result register drains in the same cycle.
// Reset (rst_ni low, asynchronous): idle, digits 10:52:53, LED off,
// timeout limit 200 ticks, passed when the tick count exceeds it; both stages empty.
// ----------------------------------------------------------------------------
module clock_setting_display_controller
  import csdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  csdc_req_if.sink    req_i,
  csdc_res_if.source  res_o
);

  // input stage
  csdc_in_t  in_q;
  logic      in_vld_q;
  // result stage
  csdc_res_t out_q, res;
  logic      out_vld_q;
  // the held word is processed when the result register is free or draining
  logic      fire;

  assign fire        = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.mode             <= req_i.mode;
      in_q.button1_level    <= req_i.button1_level;
      in_q.button2_level    <= req_i.button2_level;
      in_q.rtc_seconds_byte <= req_i.rtc_seconds_byte;
      in_q.rtc_minutes_byte <= req_i.rtc_minutes_byte;
      in_q.rtc_hours_byte   <= req_i.rtc_hours_byte;
    end
  end

  // state updates only on fire, so events apply strictly in order
  csdc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .word_i      (in_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.display_valid   = out_q.display_valid;
  assign res_o.seg_minute_ones = out_q.seg_minute_ones;
  assign res_o.seg_minute_tens = out_q.seg_minute_tens;
  assign res_o.seg_hour_ones   = out_q.seg_hour_ones;
  assign res_o.seg_hour_tens   = out_q.seg_hour_tens;
  assign res_o.led_level       = out_q.led_level;
  assign res_o.rtc_write_valid = out_q.rtc_write_valid;
  assign res_o.rtc_seconds_out = out_q.rtc_seconds_out;
  assign res_o.rtc_minutes_out = out_q.rtc_minutes_out;
  assign res_o.rtc_hours_out   = out_q.rtc_hours_out;

  // a processed word always lands in the result register
  a_fire_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> res_o.valid)
    else $error("processed word produced no result");

  // write-back and display update never share a result
  a_write_no_disp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.rtc_write_valid) |-> !res_o.display_valid)
    else $error("write-back result also carries a display update");

  // write-back always flags 12-hour mode
  a_write_12h : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.rtc_write_valid) |-> res_o.rtc_hours_out[6])
    else $error("write-back hours byte lacks the 12-hour bit");

endmodule

// File: hw/rtl/csdc_core.sv
// ----------------------------------------------------------------------------
// csdc_core: controller state and event logic
// Holds the clock state and computes one result word per event word.
// ----------------------------------------------------------------------------
module csdc_core
  import csdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  csdc_in_t    word_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output csdc_res_t   res_o
);

  clock_mode_e mode_q, mode_d;
  logic        b1_last_q, b1_last_d, b2_last_q, b2_last_d;
  logic        p1_q, p1_d, p2_q, p2_d;
  logic [1:0]  fsel_q, fsel_d;
  logic        blink_q, blink_d;
  logic [15:0] cnt_q, cnt_d, cnt_inc;
  logic [5:0]  set_min_q, set_min_d;
  logic [3:0]  set_hr_q, set_hr_d;
  logic [3:0]  dig_q [6];
  logic [3:0]  dig_d [6];
  logic        led_q, led_d;
  logic [15:0] tmo_q;
  logic        show, blank_min, blank_hr;
  logic [7:0]  min_split, hr_split;

  always_comb begin
    mode_d    = mode_q;
    b1_last_d = b1_last_q;
    b2_last_d = b2_last_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    fsel_d    = fsel_q;
    blink_d   = blink_q;
    cnt_d     = cnt_q;
    set_min_d = set_min_q;
    set_hr_d  = set_hr_q;
    dig_d     = dig_q;
    led_d     = led_q;
    show      = 1'b0;
    blank_min = 1'b0;
    blank_hr  = 1'b0;
    cnt_inc   = cnt_q + 16'd1;
    min_split = 8'd0;
    hr_split  = 8'd0;
    res_o     = '0;

    case (word_i.mode)
      EvtPoll: begin
        p1_d      = p1_q | (word_i.button1_level & ~b1_last_q);
        p2_d      = p2_q | (word_i.button2_level & ~b2_last_q);
        b1_last_d = word_i.button1_level;
        b2_last_d = word_i.button2_level;
        case (mode_q)
          ModeIdle: begin
            if (p1_d) begin
              mode_d = ModeSettings;
              p1_d   = 1'b0;
            end
          end
          ModeSettings: begin
            if (p1_d) begin
              cnt_d  = 16'd0;
              fsel_d = (fsel_q == FieldHours) ? FieldMinutes : FieldHours;
              p1_d   = 1'b0;
            end else if (p2_d) begin
              cnt_d = 16'd0;
              if (fsel_q == FieldHours) begin
                set_hr_d = (set_hr_q + 4'd1 > HoursMax) ? 4'd0 : set_hr_q + 4'd1;
              end else if (fsel_q == FieldMinutes) begin
                set_min_d = (set_min_q + 6'd1 > MinutesMax) ? 6'd0
                                                            : set_min_q + 6'd1;
              end
              if (fsel_q == FieldHours || fsel_q == FieldMinutes) begin
                min_split = split_min(set_min_d);
                hr_split  = split_hr(set_hr_d);
                dig_d[2]  = min_split[3:0];
                dig_d[3]  = min_split[7:4];
                dig_d[4]  = hr_split[3:0];
                dig_d[5]  = hr_split[7:4];
              end
              p2_d = 1'b0;
            end
          end
          default: begin
            // timeout: write the held time back and drop to idle
            res_o.rtc_write_valid = 1'b1;
            res_o.rtc_seconds_out = {dig_q[1], dig_q[0]};
            res_o.rtc_minutes_out = {dig_q[3], dig_q[2]};
            res_o.rtc_hours_out   = {dig_q[5][2:0], dig_q[4]} | Hours12Bit;
            mode_d = ModeIdle;
          end
        endcase
      end
      EvtTime: begin
        if (mode_q == ModeIdle) begin
          dig_d[0] = word_i.rtc_seconds_byte[3:0];
          dig_d[1] = word_i.rtc_seconds_byte[7:4];
          dig_d[2] = word_i.rtc_minutes_byte[3:0];
          dig_d[3] = word_i.rtc_minutes_byte[7:4];
          dig_d[4] = word_i.rtc_hours_byte[3:0];
          dig_d[5] = {3'd0, word_i.rtc_hours_byte[4]};
          show     = 1'b1;
          led_d    = ~led_q;
        end
      end
      EvtTick: begin
        if (mode_q == ModeSettings) begin
          cnt_d = cnt_inc;
          if (!blink_q) begin
            show = 1'b1;
          end else if (fsel_q == FieldMinutes) begin
            show      = 1'b1;
            blank_min = 1'b1;
          end else if (fsel_q == FieldHours) begin
            show     = 1'b1;
            blank_hr = 1'b1;
          end
          blink_d = ~blink_q;
          if (cnt_inc > tmo_q) begin
            mode_d = ModeTimeout;
            cnt_d  = 16'd0;
          end
        end
      end
      default: begin
      end
    endcase

    // the display comes from the digits as they stand after the event
    if (show) begin
      res_o.display_valid   = 1'b1;
      res_o.seg_minute_ones = blank_min ? 7'd0 : seg_of(dig_d[2]);
      res_o.seg_minute_tens = blank_min ? 7'd0 : seg_of(dig_d[3]);
      res_o.seg_hour_ones   = blank_hr  ? 7'd0 : seg_of(dig_d[4]);
      res_o.seg_hour_tens   = blank_hr  ? 7'd0 : seg_of(dig_d[5]);
    end
    res_o.led_level = led_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeIdle;
      b1_last_q <= 1'b0;
      b2_last_q <= 1'b0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      fsel_q    <= FieldNone;
      blink_q   <= 1'b0;
      cnt_q     <= 16'd0;
      set_min_q <= 6'd0;
      set_hr_q  <= 4'd0;
      dig_q[0]  <= 4'd3;
      dig_q[1]  <= 4'd5;
      dig_q[2]  <= 4'd2;
      dig_q[3]  <= 4'd5;
      dig_q[4]  <= 4'd0;
      dig_q[5]  <= 4'd1;
      led_q     <= 1'b0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      b1_last_q <= b1_last_d;
      b2_last_q <= b2_last_d;
      p1_q      <= p1_d;
      p2_q      <= p2_d;
      fsel_q    <= fsel_d;
      blink_q   <= blink_d;
      cnt_q     <= cnt_d;
      set_min_q <= set_min_d;
      set_hr_q  <= set_hr_d;
      dig_q     <= dig_d;
      led_q     <= led_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      tmo_q <= cfg_wdata_i;
    end
  end

endmodule
